>>> rtl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// shared types, constants and helpers for the pes header / pts extractor
// ----------------------------------------------------------------------------
package pes_pkg;

    // parser phases, one-hot
    typedef enum logic [8:0] {
        PH_HUNT    = 9'b0_0000_0001,
        PH_LEN_HI  = 9'b0_0000_0010,
        PH_LEN_LO  = 9'b0_0000_0100,
        PH_FLAG0   = 9'b0_0000_1000,
        PH_FLAG1   = 9'b0_0001_0000,
        PH_HDRLEN  = 9'b0_0010_0000,
        PH_HEADER  = 9'b0_0100_0000,
        PH_PAYLOAD = 9'b0_1000_0000,
        PH_SKIP    = 9'b1_0000_0000
    } phase_t;

    localparam logic [7:0]  STREAM_ID_RESET = 8'hBD;
    localparam logic [23:0] START_PREFIX    = 24'h00_0001;
    localparam int          TS_BYTES        = 10;
    localparam int          TS_IDX_W        = $clog2(TS_BYTES);
    localparam logic [15:0] MIN_LEN         = 16'd3;
    localparam logic [1:0]  SEL_PTS         = 2'b10;
    localparam logic [1:0]  SEL_PTS_DTS     = 2'b11;
    localparam logic [7:0]  PTS_MSB_CLEAR   = 8'hF7;

    typedef logic [7:0] byte_t;

    // 33-bit stamp from five header bytes, marker bits dropped
    function automatic logic [32:0] decode_stamp(
        input byte_t b0, input byte_t b1, input byte_t b2,
        input byte_t b3, input byte_t b4
    );
        decode_stamp = {b0[3:1], b1, b2[7:1], b3, b4[7:1]};
    endfunction

endpackage

>>> rtl/pes_header_pts_extractor.sv
// ----------------------------------------------------------------------------
// pes_header_pts_extractor
// hunts a byte stream for a pes start code, parses the header and tags each
// payload byte with its pts / dts and packet boundary marks
// ----------------------------------------------------------------------------
// One byte is taken per clock while in_stall is low. Each input beat updates
// the parser state in the same cycle it is accepted and, for a payload byte,
// loads a single result register, so a payload byte appears on the output in
// the next cycle; unstalled, the sustained rate is one byte per cycle. The
// result register is the only buffer: in_stall rises only while it holds a
// beat that the downstream side is stalling, so throughput follows out_stall.
// Header bytes, start-code bytes and skipped bytes produce no output beat.
// The stream id is written through the cfg port (always ready) and is
// compared at the next start-code hunt; write it only while idle.
module pes_header_pts_extractor
    import pes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    // byte stream in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [32:0] sync_time,

    // tagged payload out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic [32:0] pts_value,
    output logic        pts_present,
    output logic [32:0] dts_value,
    output logic        dts_present,
    output logic        first_of_packet,
    output logic        last_of_packet
);

    // parser state
    phase_t      phase_reg,         phase_next;
    logic [31:0] window_reg,        window_next;
    logic [15:0] bytes_left_reg,    bytes_left_next;
    logic [7:0]  header_len_reg,    header_len_next;
    logic [7:0]  header_idx_reg,    header_idx_next;
    logic [7:0]  flag_reg,          flag_next;
    byte_t       ts_reg [TS_BYTES];
    byte_t       ts_next [TS_BYTES];
    logic        first_pend_reg,    first_pend_next;
    logic [7:0]  stream_id_reg;

    // result register
    logic        out_valid_reg,     out_valid_next;
    logic [7:0]  payload_reg;
    logic [32:0] pts_reg;
    logic        pts_pres_reg;
    logic [32:0] dts_reg;
    logic        dts_pres_reg;
    logic        first_reg;
    logic        last_reg;

    logic        in_accept;
    logic        emit;
    logic        has_pts;
    logic        has_dts;
    logic [7:0]  ts0_eff;
    logic [15:0] len_full;
    logic [15:0] bl_dec;
    logic [7:0]  idx_inc;
    logic [32:0] pts_calc;
    logic [32:0] dts_calc;

    assign cfg_ready = 1'b1;

    // stall only when the result register is full and cannot drain
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign has_pts  = (flag_reg[7:6] == SEL_PTS) || (flag_reg[7:6] == SEL_PTS_DTS);
    assign has_dts  = (flag_reg[7:6] == SEL_PTS_DTS);
    assign len_full = {bytes_left_reg[15:8], data_byte};
    assign bl_dec   = bytes_left_reg - 16'd1;
    assign idx_inc  = header_idx_reg + 8'd1;

    // pts bit 32 drops on the first payload byte when sync time is 32-bit
    assign ts0_eff = (first_pend_reg && has_pts && !sync_time[32])
                   ? (ts_reg[0] & PTS_MSB_CLEAR) : ts_reg[0];

    assign pts_calc = has_pts
                    ? decode_stamp(ts0_eff, ts_reg[1], ts_reg[2], ts_reg[3], ts_reg[4])
                    : 33'd0;
    assign dts_calc = has_dts
                    ? decode_stamp(ts_reg[5], ts_reg[6], ts_reg[7], ts_reg[8], ts_reg[9])
                    : 33'd0;

    always_comb
    begin
        phase_next      = phase_reg;
        window_next     = window_reg;
        bytes_left_next = bytes_left_reg;
        header_len_next = header_len_reg;
        header_idx_next = header_idx_reg;
        flag_next       = flag_reg;
        first_pend_next = first_pend_reg;
        emit            = 1'b0;
        for (int i = 0; i < TS_BYTES; i++)
        begin
            ts_next[i] = ts_reg[i];
        end

        if (in_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    // window only shifts while hunting
                    window_next = {window_reg[23:0], data_byte};
                    if ({window_reg[23:0], data_byte} == {START_PREFIX, stream_id_reg})
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    bytes_left_next = {data_byte, 8'd0};
                    phase_next      = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (len_full < MIN_LEN)
                    begin
                        bytes_left_next = len_full;
                        phase_next      = (len_full == 16'd0) ? PH_HUNT : PH_SKIP;
                    end
                    else
                    begin
                        bytes_left_next = len_full - MIN_LEN;
                        phase_next      = PH_FLAG0;
                    end
                end
                PH_FLAG0:
                begin
                    phase_next = PH_FLAG1;
                end
                PH_FLAG1:
                begin
                    flag_next  = data_byte;
                    phase_next = PH_HDRLEN;
                end
                PH_HDRLEN:
                begin
                    header_len_next = data_byte;
                    if (bytes_left_reg < {8'd0, data_byte})
                    begin
                        // header runs past the packet: skip the rest
                        phase_next = (bytes_left_reg == 16'd0) ? PH_HUNT : PH_SKIP;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - {8'd0, data_byte};
                        header_idx_next = 8'd0;
                        for (int i = 0; i < TS_BYTES; i++)
                        begin
                            ts_next[i] = 8'd0;
                        end
                        if (data_byte == 8'd0)
                        begin
                            if (bytes_left_next != 16'd0)
                            begin
                                first_pend_next = 1'b1;
                                phase_next      = PH_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                PH_HEADER:
                begin
                    // header bytes past the tenth are dropped
                    if (header_idx_reg < 8'(TS_BYTES))
                    begin
                        ts_next[header_idx_reg[TS_IDX_W-1:0]] = data_byte;
                    end
                    header_idx_next = idx_inc;
                    if (idx_inc >= header_len_reg)
                    begin
                        if (bytes_left_reg != 16'd0)
                        begin
                            first_pend_next = 1'b1;
                            phase_next      = PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    emit            = 1'b1;
                    ts_next[0]      = ts0_eff;
                    first_pend_next = 1'b0;
                    bytes_left_next = bl_dec;
                    if (bl_dec == 16'd0)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SKIP:
                begin
                    if (bytes_left_reg != 16'd0)
                    begin
                        bytes_left_next = bl_dec;
                    end
                    if (bytes_left_reg <= 16'd1)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // result register: load on a payload beat, clear once taken
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            window_reg     <= 32'd0;
            bytes_left_reg <= 16'd0;
            header_len_reg <= 8'd0;
            header_idx_reg <= 8'd0;
            flag_reg       <= 8'd0;
            first_pend_reg <= 1'b0;
            stream_id_reg  <= STREAM_ID_RESET;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TS_BYTES; i++)
            begin
                ts_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            bytes_left_reg <= bytes_left_next;
            header_len_reg <= header_len_next;
            header_idx_reg <= header_idx_next;
            flag_reg       <= flag_next;
            first_pend_reg <= first_pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                stream_id_reg <= cfg_data;
            end
            for (int i = 0; i < TS_BYTES; i++)
            begin
                ts_reg[i] <= ts_next[i];
            end
        end
    end

    // payload fields, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            payload_reg  <= data_byte;
            pts_reg      <= pts_calc;
            pts_pres_reg <= has_pts;
            dts_reg      <= dts_calc;
            dts_pres_reg <= has_dts;
            first_reg    <= first_pend_reg;
            last_reg     <= (bl_dec == 16'd0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_byte    = payload_reg;
    assign pts_value       = pts_reg;
    assign pts_present     = pts_pres_reg;
    assign dts_value       = dts_reg;
    assign dts_present     = dts_pres_reg;
    assign first_of_packet = first_reg;
    assign last_of_packet  = last_reg;

endmodule

>>> rtl/pes_checker.sv
// ----------------------------------------------------------------------------
// pes_checker
// port-level checks for the pes header / pts extractor, bound to the top
// ----------------------------------------------------------------------------
module pes_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  payload_byte,
    input  logic [32:0] pts_value,
    input  logic        pts_present,
    input  logic [32:0] dts_value,
    input  logic        dts_present,
    input  logic        first_of_packet,
    input  logic        last_of_packet
);

    logic out_beat;
    logic expect_first_reg;

    assign out_beat = out_valid & ~out_stall;

    // a new packet starts after reset and after every last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_first_reg <= 1'b1;
        end
        else if (out_beat)
        begin
            expect_first_reg <= last_of_packet;
        end
    end

    // input backs up only behind a held result
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without a pending result");

    a_first_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (first_of_packet == expect_first_reg))
        else $error("first mark out of step with packet boundaries");

    a_stamp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pts_present || (pts_value == 33'd0 && !dts_present))
                       && (dts_present || dts_value == 33'd0)))
        else $error("time stamp value or flag inconsistent");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
                                   && $stable(last_of_packet) && $stable(pts_value))
        else $error("stalled result changed");

endmodule

bind pes_header_pts_extractor pes_checker u_pes_checker (.*);
